FILE: rtl/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int KEY_W = 20;
  localparam int VAL_W = 20;
  localparam int OP_W  = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             status;
  } out_item_t;

  // Outcome of one table scan.
  typedef struct packed {
    logic hit;
    logic has_free;
  } scan_flags_t;

endpackage

FILE: rtl/kvt_ram.sv
`timescale 1ns / 1ps

module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/kvt_match.sv
`timescale 1ns / 1ps

module kvt_match #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           cmp_vld,
  input  logic [$clog2(TABLE_DEPTH)-1:0] cmp_idx,
  input  logic                           cmp_word_valid,
  input  logic [kvt_pkg::KEY_W-1:0]      cmp_key,
  input  logic [kvt_pkg::VAL_W-1:0]      cmp_value,
  input  logic [kvt_pkg::KEY_W-1:0]      target_key,
  output kvt_pkg::scan_flags_t           flags,
  output logic [$clog2(TABLE_DEPTH)-1:0] hit_idx,
  output logic [kvt_pkg::VAL_W-1:0]      hit_value,
  output logic [$clog2(TABLE_DEPTH)-1:0] free_idx
);

  localparam int AW = $clog2(TABLE_DEPTH);

  kvt_pkg::scan_flags_t flags_r;
  logic [AW-1:0]             hit_idx_r;
  logic [kvt_pkg::VAL_W-1:0] hit_value_r;
  logic [AW-1:0]             free_idx_r;
  logic                      key_eq;
  logic                      take_hit;
  logic                      take_free;

  // The shared key comparator, applied to one entry per cycle.
  assign key_eq    = (cmp_key == target_key);
  assign take_hit  = cmp_vld && !flags_r.hit && cmp_word_valid && key_eq;
  assign take_free = cmp_vld && !flags_r.has_free && !cmp_word_valid;

  // Flags keep only the lowest-indexed match and free entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (start) begin
      flags_r <= '0;
    end else begin
      if (take_hit) begin
        flags_r.hit <= 1'b1;
      end
      if (take_free) begin
        flags_r.has_free <= 1'b1;
      end
    end
  end

  // Captured index and value of the first match and first free entry.
  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx_r   <= cmp_idx;
      hit_value_r <= cmp_value;
    end
    if (take_free) begin
      free_idx_r <= cmp_idx;
    end
  end

  assign flags     = flags_r;
  assign hit_idx   = hit_idx_r;
  assign hit_value = hit_value_r;
  assign free_idx  = free_idx_r;

endmodule

FILE: rtl/key_value_table_core.sv
`timescale 1ns / 1ps

// Key/value table of TABLE_DEPTH entries searched linearly from entry 0 up. Each
// accepted item (put, get or remove) gives exactly one result item: a start step, a
// scan that streams every entry through the single key comparator from the key
// memory's one read port, a write-back step and a load of the result register, which
// waits while an earlier result is still held by out_stall. A new item is accepted the
// cycle after the result is loaded, even while that result still waits to be taken.
// After reset, a clearing pass marks every entry free; no item is accepted during it.
// A put that finds neither its key nor a free entry is dropped and reports status 1.

module key_value_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kvt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output kvt_pkg::out_item_t  out_item
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int KWORD_W = kvt_pkg::KEY_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic                    issued_all_r, issued_all_nxt;
  logic                    cmp_vld_r;
  logic [AW-1:0]           cmp_idx_r;
  kvt_pkg::in_item_t       req_r;
  logic                    out_valid_r;
  kvt_pkg::out_item_t      out_item_r;

  logic                    rd_en;
  logic                    key_we;
  logic [AW-1:0]           key_waddr;
  logic [KWORD_W-1:0]      key_wdata;
  logic [KWORD_W-1:0]      key_rdata;
  logic                    val_we;
  logic [AW-1:0]           val_waddr;
  logic [kvt_pkg::VAL_W-1:0] val_rdata;
  logic                    start;
  logic                    out_load;
  kvt_pkg::out_item_t      res;

  kvt_pkg::scan_flags_t    flags;
  logic [AW-1:0]           hit_idx;
  logic [AW-1:0]           free_idx;
  logic [kvt_pkg::VAL_W-1:0] hit_value;

  logic                    op_put;
  logic                    op_get;
  logic                    op_remove;

  assign op_put    = (req_r.opcode == kvt_pkg::OP_PUT);
  assign op_get    = (req_r.opcode == kvt_pkg::OP_GET);
  assign op_remove = (req_r.opcode == kvt_pkg::OP_REMOVE);

  // Key memory holds the valid mark above the key.
  kvt_ram #(
    .WIDTH (KWORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (key_wdata),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (key_rdata)
  );

  kvt_ram #(
    .WIDTH (kvt_pkg::VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (req_r.value),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (val_rdata)
  );

  kvt_match #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_match (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .cmp_vld        (cmp_vld_r),
    .cmp_idx        (cmp_idx_r),
    .cmp_word_valid (key_rdata[KWORD_W-1]),
    .cmp_key        (key_rdata[kvt_pkg::KEY_W-1:0]),
    .cmp_value      (val_rdata),
    .target_key     (req_r.key),
    .flags          (flags),
    .hit_idx        (hit_idx),
    .hit_value      (hit_value),
    .free_idx       (free_idx)
  );

  // Sequencer: clear pass, scan, write-back and result.
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    issued_all_nxt = issued_all_r;
    rd_en          = 1'b0;
    key_we         = 1'b0;
    key_waddr      = addr_r;
    key_wdata      = '0;
    val_we         = 1'b0;
    val_waddr      = hit_idx;
    start          = 1'b0;
    out_load       = 1'b0;
    res            = '0;
    case (state_r)
      ST_CLEAR: begin
        key_we = 1'b1;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          start          = 1'b1;
          addr_nxt       = '0;
          issued_all_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issued_all_r) begin
          rd_en = 1'b1;
          if (addr_r == LAST_IDX) begin
            issued_all_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (cmp_vld_r && (cmp_idx_r == LAST_IDX)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (op_put) begin
          if (flags.hit) begin
            val_we = 1'b1;
          end else if (flags.has_free) begin
            key_we    = 1'b1;
            key_waddr = free_idx;
            key_wdata = {1'b1, req_r.key};
            val_we    = 1'b1;
            val_waddr = free_idx;
          end
        end else if (op_remove && flags.hit) begin
          key_we    = 1'b1;
          key_waddr = hit_idx;
          key_wdata = {1'b0, req_r.key};
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res.found      = flags.hit && (op_put || op_get || op_remove);
        res.read_value = (op_get && flags.hit) ? hit_value : '0;
        res.status     = (op_put && !flags.hit && !flags.has_free) ?
                         kvt_pkg::STATUS_FULL : kvt_pkg::STATUS_OK;
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        addr_nxt  = '0;
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      addr_r       <= '0;
      issued_all_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      issued_all_r <= issued_all_nxt;
      cmp_vld_r    <= rd_en;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    if (start) begin
      req_r <= in_item;
    end
    if (out_load) begin
      out_item_r <= res;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // An accepted item always starts a scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN))
    else $error("accepted item did not start a scan");

  // The memories are only read, never written, while a scan runs.
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (!key_we && !val_we))
    else $error("table written during scan");

  // A dropped put never reports a hit.
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.status && out_item.found))
    else $error("full status together with found");

  // A nonzero read value only comes with a hit.
  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.read_value != '0)) |-> out_item.found)
    else $error("read value without a hit");

endmodule
